FILE: rtl/rcfr_pkg.sv
package rcfr_pkg;

  localparam int BufferBytes   = 64;
  localparam int PayloadKeep   = 22;
  localparam int NumChannels   = 16;
  localparam int ChanBits      = 11;
  localparam int MinChannelLen = 23;

  // byte position within a frame; the last one is BufferBytes - 1
  localparam int CountW = $clog2(BufferBytes);
  localparam int IdxW   = $clog2(PayloadKeep);
  localparam int ChIdxW = $clog2(NumChannels);
  localparam int PayW   = PayloadKeep * 8;

  localparam logic [7:0] CrcPoly   = 8'hD5;
  localparam logic [7:0] SyncReset = 8'd200;
  localparam logic [7:0] TypeReset = 8'd22;

  // register index, taken from paddr[2]
  localparam logic RegSync = 1'b0;
  localparam logic RegType = 1'b1;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] channels_type;
  } cfg_t;

  typedef struct packed {
    logic            good;     // accepted frame passed all checks
    logic [PayW-1:0] payload;  // stored payload, byte 0 at the low end
  } frame_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/rcfr_if.sv
interface rcfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfr_chan_if;
  logic                          valid;
  logic                          ready;
  logic [rcfr_pkg::ChIdxW-1:0]   channel_index;
  logic [rcfr_pkg::ChanBits-1:0] channel_value;
  logic                          last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

FILE: rtl/rc_channel_frame_receiver.sv
// RC channel frame receiver. Serial bytes enter on rx_i, one per transaction, and
// each is taken when valid and ready meet: the block hunts for the sync byte, reads the
// length byte (frames longer than the buffer are dropped), runs a CRC-8 (poly 0xD5)
// over type and payload, and keeps the first 22 payload bytes. When the CRC byte
// closes a frame whose CRC, type and length (>= 23) all check out, the payload is
// copied into an output snapshot and sixteen 11-bit channels leave on ch_o, one per
// transaction, channel 0 first, last_channel flagging channel 15. Input takes one
// byte per cycle; the only stall is on a CRC byte that arrives while the snapshot
// of the previous frame is still draining (16 output transactions). Registers:
// 0x0 sync byte (reset 200), 0x4 channels type (reset 22), written over APB.
module rc_channel_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rcfr_byte_if.sink   rx_i,
  rcfr_chan_if.source ch_o
);

  rcfr_pkg::cfg_t   cfg;
  rcfr_pkg::frame_t frame;
  logic             busy;

  // configuration registers
  rcfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // byte-level frame state, CRC and payload store
  rcfr_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .busy_i  (busy),
    .rx_i    (rx_i),
    .frame_o (frame)
  );

  // snapshot and channel output
  rcfr_drain u_drain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .busy_o  (busy),
    .ch_o    (ch_o)
  );

endmodule

FILE: rtl/rcfr_cfg.sv
module rcfr_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rcfr_pkg::cfg_t      cfg_o
);

  rcfr_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value    <= rcfr_pkg::SyncReset;
      cfg_q.channels_type <= rcfr_pkg::TypeReset;
    end else if (wr_en) begin
      case (paddr[2])
        rcfr_pkg::RegSync: cfg_q.sync_value    <= pwdata[7:0];
        rcfr_pkg::RegType: cfg_q.channels_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rcfr_pkg::RegSync: prdata = {24'd0, cfg_q.sync_value};
      rcfr_pkg::RegType: prdata = {24'd0, cfg_q.channels_type};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rcfr_parser.sv
module rcfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcfr_pkg::cfg_t      cfg_i,
  input  logic                busy_i,   // output side still draining a frame
  rcfr_byte_if.sink           rx_i,
  output rcfr_pkg::frame_t    frame_o
);

  logic [rcfr_pkg::CountW-1:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] type_q, type_d;
  logic [7:0] store_q [rcfr_pkg::PayloadKeep];

  logic       take;
  logic       at_crc;
  logic [8:0] end_pos;
  logic [8:0] total_len;
  logic [rcfr_pkg::CountW-1:0] pay_idx;
  logic       store_en;

  assign end_pos   = 9'd2 + {1'b0, len_q};
  assign total_len = 9'd3 + {1'b0, rx_i.rx_byte};
  assign at_crc    = (pos_q > rcfr_pkg::CountW'(1)) &&
                     ({{(9-rcfr_pkg::CountW){1'b0}}, pos_q} >= end_pos);

  // hold the CRC byte back while the previous frame is still going out
  assign rx_i.ready = !(busy_i && at_crc);
  assign take       = rx_i.valid && rx_i.ready;

  assign pay_idx  = pos_q - rcfr_pkg::CountW'(3);

  always_comb begin
    pos_d         = pos_q;
    len_d         = len_q;
    crc_d         = crc_q;
    type_d        = type_q;
    store_en      = 1'b0;
    frame_o.good  = 1'b0;
    for (int i = 0; i < rcfr_pkg::PayloadKeep; i++) begin
      frame_o.payload[8*i +: 8] = store_q[i];
    end
    if (take) begin
      if (pos_q == '0) begin
        if (rx_i.rx_byte == cfg_i.sync_value) pos_d = rcfr_pkg::CountW'(1);
      end else if (pos_q == rcfr_pkg::CountW'(1)) begin
        len_d = rx_i.rx_byte;
        crc_d = 8'd0;
        if (total_len > 9'(rcfr_pkg::BufferBytes)) pos_d = '0;
        else pos_d = rcfr_pkg::CountW'(2);
      end else if (at_crc) begin
        frame_o.good = (rx_i.rx_byte == crc_q) && (type_q == cfg_i.channels_type) &&
                       (len_q >= 8'(rcfr_pkg::MinChannelLen));
        pos_d = '0;
      end else begin
        crc_d = rcfr_pkg::crc8_step(crc_q, rx_i.rx_byte);
        if (pos_q == rcfr_pkg::CountW'(2)) type_d = rx_i.rx_byte;
        else store_en = (pay_idx < rcfr_pkg::CountW'(rcfr_pkg::PayloadKeep));
        pos_d = pos_q + rcfr_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= 8'd0;
      crc_q  <= 8'd0;
      type_q <= 8'd0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      type_q <= type_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      store_q[pay_idx[rcfr_pkg::IdxW-1:0]] <= rx_i.rx_byte;
    end
  end

endmodule

FILE: rtl/rcfr_drain.sv
module rcfr_drain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcfr_pkg::frame_t    frame_i,
  output logic                busy_o,
  rcfr_chan_if.source         ch_o
);

  logic [rcfr_pkg::PayW-1:0]   snap_q;
  logic [rcfr_pkg::ChIdxW-1:0] cnt_q;
  logic                        busy_q;
  logic                        pop;
  logic                        last;

  assign last = (cnt_q == rcfr_pkg::ChIdxW'(rcfr_pkg::NumChannels - 1));
  assign pop  = busy_q && ch_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (frame_i.good) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (pop) begin
      busy_q <= !last;
      cnt_q  <= cnt_q + rcfr_pkg::ChIdxW'(1);
    end
  end

  // snapshot frees the payload store for the next frame; shifts one channel per transaction
  always_ff @(posedge clk_i) begin
    if (frame_i.good) begin
      snap_q <= frame_i.payload;
    end else if (pop) begin
      snap_q <= snap_q >> rcfr_pkg::ChanBits;
    end
  end

  assign busy_o             = busy_q;
  assign ch_o.valid         = busy_q;
  assign ch_o.channel_index = cnt_q;
  assign ch_o.channel_value = snap_q[rcfr_pkg::ChanBits-1:0];
  assign ch_o.last_channel  = last;

endmodule
